FILE: rtl/sira_pkg.sv
// Shared types, constants and helpers for the signed integer to radix ASCII converter.
`default_nettype none

package sira_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int RADIX_W            = 6;
   localparam int DIGIT_W            = 6;
   localparam int CHAR_W             = 8;
   localparam int BITS_PER_CYCLE     = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_LAST  = 6'd35;

   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ZERO,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

   // Out-of-range radix codes clamp to the nearest legal base.
   function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] radix);
      logic [RADIX_W-1:0] result;
      if (radix < RADIX_MIN) begin
         result = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         result = RADIX_MAX;
      end else begin
         result = radix;
      end
      return result;
   endfunction

   // Digit value to upper-case ASCII, codes past 'Z' read as 'Z'.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit);
      logic [DIGIT_W-1:0] clamped;
      logic [CHAR_W-1:0]  result;
      clamped = (digit > DIGIT_LAST) ? DIGIT_LAST : digit;
      if (clamped < DIGIT_TEN) begin
         result = CHAR_ZERO + {2'b00, clamped};
      end else begin
         result = CHAR_UPPER_A + {2'b00, clamped - DIGIT_TEN};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/signed_integer_to_radix_ascii.sv
// Top level: signed integer to ASCII text in a programmable radix.
//
// Usage:
//  - Request channel: a request is taken at a clock edge with start high and
//    busy low. busy stays high from the next cycle until the last character
//    of that request has been produced.
//  - Response channel: each character shows on rsp_character for exactly one
//    cycle with rsp_strobe high; rsp_final_char marks the last one. The
//    receiver cannot stall, so characters leave at once.
//  - CSR channel: csr_radix is taken when csr_valid and csr_ready are both
//    high; csr_ready is high whenever the block is not busy. Radix 0 or 1
//    acts as 2, radix above 36 acts as 36.
//  - Flow: each digit is produced by a restoring divide with 8 steps per
//    cycle and is then written to the digit store, least significant first.
//    A negative request adds a leading minus sign. A zero request skips
//    the divider and emits a single '0'. The first character appears after
//    the divide phase; the digits then leave one per cycle.
//  - Reset (synchronous, active high) idles the sequencer, clears the
//    strobe and loads radix 10. The digit store is not cleared.
`default_nettype none

module signed_integer_to_radix_ascii #(
   parameter int VALUE_BITS = sira_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [VALUE_BITS-1:0]        req_number,
   // response
   output logic                                     rsp_strobe,
   output logic             [sira_pkg::CHAR_W-1:0]  rsp_character,
   output logic                                     rsp_final_char,
   // CSR
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [sira_pkg::RADIX_W-1:0] csr_radix
);
   import sira_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int IDX_W = $clog2(VALUE_BITS);

   state_type state_ff, state_in;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               negative_ff, negative_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [CHAR_W-1:0]  rsp_character_ff, rsp_character_in;
   logic               rsp_final_ff, rsp_final_in;

   // request decode
   logic                  accept;
   logic                  in_negative;
   logic [VALUE_BITS-1:0] in_bits;
   logic [VALUE_BITS-1:0] in_magnitude;

   // divider hookup
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   div_status_type        div_status;
   logic [VALUE_BITS-1:0] div_quotient;
   logic                  div_last;

   // digit store hookup
   logic                  st_wr_en;
   logic                  st_rd_en;
   logic [CNT_W-1:0]      rd_index;
   logic [DIGIT_W-1:0]    st_rd_data;

   assign accept       = start && !busy;
   assign in_bits      = req_number;
   assign in_negative  = in_bits[VALUE_BITS-1];
   // Two's complement negate; the most negative value maps to its unsigned magnitude.
   assign in_magnitude = in_negative ? (~in_bits + VALUE_BITS'(1)) : in_bits;

   // Last digit when the quotient runs out, or the store is full.
   assign div_last = (div_quotient == '0) || (count_ff == CNT_W'(VALUE_BITS - 1));

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (in_magnitude == '0) ? ST_ZERO : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done && div_last) begin
               state_in = negative_ff ? ST_SIGN : ST_READ;
            end
         end
         ST_ZERO: state_in = ST_IDLE;
         ST_SIGN: state_in = ST_READ;
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath control and outputs ----------------
   always_comb begin
      radix_in         = radix_ff;
      count_in         = count_ff;
      negative_in      = negative_ff;
      div_start        = 1'b0;
      div_dividend     = div_quotient;
      st_wr_en         = 1'b0;
      st_rd_en         = 1'b0;
      rd_index         = count_ff - CNT_W'(1);
      rsp_strobe_in    = 1'b0;
      rsp_character_in = CHAR_ZERO;
      rsp_final_in     = 1'b0;

      if (csr_valid && csr_ready) begin
         radix_in = csr_radix;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               negative_in  = in_negative;
               count_in     = '0;
               div_dividend = in_magnitude;
               div_start    = (in_magnitude != '0);
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               st_wr_en  = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               div_start = !div_last;
            end
         end
         ST_ZERO: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = CHAR_ZERO;
            rsp_final_in     = 1'b1;
         end
         ST_SIGN: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = CHAR_MINUS;
         end
         ST_READ: begin
            // prime the read of the most significant digit
            st_rd_en = 1'b1;
         end
         ST_EMIT: begin
            rsp_strobe_in    = 1'b1;
            rsp_character_in = digit_char(st_rd_data);
            rsp_final_in     = (count_ff == CNT_W'(1));
            count_in         = count_ff - CNT_W'(1);
            // fetch the next digit while this one goes out
            rd_index         = count_ff - CNT_W'(2);
            st_rd_en         = (count_ff != CNT_W'(1));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radix_ff      <= RADIX_RESET;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_ff      <= radix_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      negative_ff      <= negative_in;
      rsp_character_ff <= rsp_character_in;
      rsp_final_ff     <= rsp_final_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_character  = rsp_character_ff;
   assign rsp_final_char = rsp_final_ff;

   sira_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (effective_radix(radix_ff)),
      .status   (div_status),
      .quotient (div_quotient)
   );

   sira_digit_store #(
      .VALUE_BITS (VALUE_BITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (div_status.remainder),
      .rd_en   (st_rd_en),
      .rd_addr (rd_index[IDX_W-1:0]),
      .rd_data (st_rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/sira_divider.sv
// Iterative restoring divider: value by radix, several quotient bits per cycle.
`default_nettype none

module sira_divider #(
   parameter int VALUE_BITS = sira_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [VALUE_BITS-1:0]        dividend,
   input  wire logic [sira_pkg::RADIX_W-1:0] divisor,
   output sira_pkg::div_status_type          status,
   output logic      [VALUE_BITS-1:0]        quotient
);
   import sira_pkg::*;

   localparam int STEPS  = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
   localparam int PAD    = STEPS * BITS_PER_CYCLE;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [PAD-1:0]     work_ff, work_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] divisor_ff, divisor_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               active_ff, active_in;
   logic               done_ff, done_in;

   logic [PAD-1:0]     iter_work;
   logic [DIGIT_W-1:0] iter_rem;

   // One register pass retires BITS_PER_CYCLE quotient bits.
   always_comb begin
      logic [DIGIT_W:0] trial;
      iter_work = work_ff;
      iter_rem  = rem_ff;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial     = {iter_rem, iter_work[PAD-1]};
         iter_work = {iter_work[PAD-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            iter_rem     = DIGIT_W'(trial - {1'b0, divisor_ff});
            iter_work[0] = 1'b1;
         end else begin
            iter_rem = trial[DIGIT_W-1:0];
         end
      end
   end

   always_comb begin
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      active_in  = active_ff;
      done_in    = 1'b0;
      if (start) begin
         work_in    = PAD'(dividend);
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = STEP_W'(STEPS);
         active_in  = 1'b1;
      end else if (active_ff) begin
         work_in = iter_work;
         rem_in  = iter_rem;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;
   assign quotient         = work_ff[VALUE_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/sira_digit_store.sv
// Digit store: one write port, one registered read port.
`default_nettype none

module sira_digit_store #(
   parameter int VALUE_BITS = sira_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(VALUE_BITS)-1:0]   wr_addr,
   input  wire logic [sira_pkg::DIGIT_W-1:0]    wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(VALUE_BITS)-1:0]   rd_addr,
   output logic      [sira_pkg::DIGIT_W-1:0]    rd_data
);
   import sira_pkg::*;

   logic [DIGIT_W-1:0] mem_ff [VALUE_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sira_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none

module sira_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_strobe,
   input wire logic [sira_pkg::CHAR_W-1:0] rsp_character,
   input wire logic                        rsp_final_char,
   input wire logic                        csr_valid,
   input wire logic                        csr_ready
);
   import sira_pkg::*;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   a_gap_after_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_char) |=> !rsp_strobe)
      else $error("character right after final character");

   a_minus_not_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_character == CHAR_MINUS)) |-> !rsp_final_char)
      else $error("minus sign flagged as final");

   a_idle_only_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !busy) |-> rsp_final_char)
      else $error("non-final character while idle");

   a_csr_when_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy)
      else $error("radix write taken while busy");

endmodule

bind signed_integer_to_radix_ascii sira_checker u_sira_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_character  (rsp_character),
   .rsp_final_char (rsp_final_char),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);

`default_nettype wire
